>>> src/wbpf_pkg.sv
// Shared types, constants and register codes of the wildcard byte pattern finder.
package wbpf_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int OFFSET_BITS_DEF = 20;
	localparam int PAT_BYTES = 16;
	localparam int LEN_W = 5;
	localparam int POS_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW      = 3'd0,
		REG_PATTERN_HIGH     = 3'd1,
		REG_PATTERN_LENGTH   = 3'd2,
		REG_WILD_MASK        = 3'd3,
		REG_REPLACEMENT_LOW  = 3'd4,
		REG_REPLACEMENT_HIGH = 3'd5,
		REG_REPLACEMENT_MASK = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [PAT_BYTES-1:0][7:0] pattern;
		logic [LEN_W-1:0]          length;
		logic [PAT_BYTES-1:0]      wild;
		logic [PAT_BYTES-1:0][7:0] repl;
		logic [PAT_BYTES-1:0]      repl_mask;
	} cfg_t;

	// What one cell shows: its byte, its compare verdict and where it sits in the pattern.
	typedef struct packed {
		logic [7:0]       data;
		logic             ok;
		logic             used;
		logic [POS_W-1:0] pos;
	} cell_stat_t;

endpackage

>>> src/wbpf_in_if.sv
// Byte stream channel: valid, ready and one buffer byte with its last flag.
interface wbpf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> src/wbpf_out_if.sv
// Search report channel: valid, ready and the result of one buffer.
interface wbpf_out_if #(
	parameter int OFFSET_BITS = wbpf_pkg::OFFSET_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   found;
	logic [OFFSET_BITS-1:0] match_offset;
	logic [63:0]            matched_low;
	logic [63:0]            matched_high;
	logic [63:0]            patched_low;
	logic [63:0]            patched_high;

	modport source (output valid, output found, output match_offset, output matched_low,
		output matched_high, output patched_low, output patched_high, input ready);
	modport sink (input valid, input found, input match_offset, input matched_low,
		input matched_high, input patched_low, input patched_high, output ready);
endinterface

>>> src/wbpf_cell.sv
// One window cell: holds a byte, passes it to its older neighbor and checks it.
module wbpf_cell #(
	parameter int POS = 0,
	parameter int PATTERN_MAX = wbpf_pkg::PATTERN_MAX_DEF
) (
	input  logic                                     clk,
	input  logic                                     shift_en,
	input  logic [7:0]                               byte_in,
	input  logic [wbpf_pkg::PAT_BYTES-1:0][7:0]      pattern,
	input  logic [wbpf_pkg::PAT_BYTES-1:0]           wild,
	input  logic [wbpf_pkg::LEN_W-1:0]               len_eff,
	output wbpf_pkg::cell_stat_t                     stat
);
	import wbpf_pkg::*;

	logic [7:0]       data_q;
	logic [LEN_W:0]   sum;
	logic             used;
	logic [POS_W-1:0] pos;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= byte_in;
		end
	end

	// The newest cell lines up with the last pattern byte, so the alignment follows the length.
	always_comb begin
		sum  = (LEN_W+1)'(POS) + {1'b0, len_eff};
		used = sum >= (LEN_W+1)'(PATTERN_MAX);
		pos  = POS_W'(sum - (LEN_W+1)'(PATTERN_MAX));
	end

	assign stat.data = data_q;
	assign stat.used = used;
	assign stat.pos  = pos;
	assign stat.ok   = !used || wild[pos] || (data_q == pattern[pos]);

endmodule

>>> src/wbpf_track.sv
// Byte counter, first-match capture and report register behind the cell chain.
module wbpf_track #(
	parameter int PATTERN_MAX = wbpf_pkg::PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = wbpf_pkg::OFFSET_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_last,
	output logic                                 adv,
	input  wbpf_pkg::cell_stat_t [PATTERN_MAX-1:0] cells,
	input  wbpf_pkg::cfg_t                       cfg,
	input  logic [wbpf_pkg::LEN_W-1:0]           len_eff,
	wbpf_out_if.source                           report
);
	import wbpf_pkg::*;

	localparam int CNT_W = OFFSET_BITS + 1;

	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_next;
	logic [CNT_W-1:0]       start;
	logic                   check_now;
	logic                   accept;

	logic                   valid_s1;
	logic                   last_s1;
	logic                   check_s1;
	logic [OFFSET_BITS-1:0] start_s1;

	logic                   match_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [PAT_BYTES-1:0][7:0] cap_q;

	logic [PAT_BYTES-1:0][7:0] cap_win;
	logic [PAT_BYTES-1:0][7:0] cap_next;
	logic [PAT_BYTES-1:0][7:0] patched;
	logic                   all_ok;
	logic                   hit;
	logic                   match_now;
	logic [OFFSET_BITS-1:0] off_next;

	logic                   out_valid_q;
	logic                   found_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [PAT_BYTES-1:0][7:0] matched_q;
	logic [PAT_BYTES-1:0][7:0] patched_q;

	// Only a finished buffer blocked by a full report register holds the pipeline.
	assign adv    = !(valid_s1 && last_s1 && out_valid_q && !report.ready);
	assign accept = in_valid && adv;

	always_comb begin
		count_next = count_q + CNT_W'(1);
		start      = count_next - CNT_W'(len_eff);
		check_now  = !(&count_q) && (len_eff != '0) && (count_next >= CNT_W'(len_eff))
			&& !start[CNT_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			check_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			if (accept) begin
				last_s1  <= in_last;
				check_s1 <= check_now;
				if (in_last) begin
					count_q <= '0;
				end else if (!(&count_q)) begin
					count_q <= count_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && accept) begin
			start_s1 <= start[OFFSET_BITS-1:0];
		end
	end

	// Each pattern position collects the byte of the one cell aligned to it.
	always_comb begin
		cap_win = '0;
		for (int i = 0; i < PAT_BYTES; i++) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				if (cells[k].used && cells[k].pos == POS_W'(i)) begin
					cap_win[i] = cap_win[i] | cells[k].data;
				end
			end
		end
	end

	always_comb begin
		all_ok = 1'b1;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			all_ok = all_ok & cells[k].ok;
		end
		hit       = valid_s1 && check_s1 && !match_q && all_ok;
		match_now = match_q || hit;
		cap_next  = hit ? cap_win : cap_q;
		off_next  = hit ? start_s1 : off_q;
		for (int i = 0; i < PAT_BYTES; i++) begin
			if (match_now && (LEN_W'(i) < len_eff) && cfg.repl_mask[i]) begin
				patched[i] = cap_next[i];
			end else begin
				patched[i] = cfg.repl[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (adv && valid_s1) begin
			match_q <= match_now && !last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			cap_q <= cap_next;
			off_q <= off_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && valid_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && last_s1) begin
			found_q   <= match_now;
			offset_q  <= match_now ? off_next : '0;
			matched_q <= match_now ? cap_next : '0;
			patched_q <= patched;
		end
	end

	assign report.valid        = out_valid_q;
	assign report.found        = found_q;
	assign report.match_offset = offset_q;
	assign report.matched_low  = matched_q[7:0];
	assign report.matched_high = matched_q[15:8];
	assign report.patched_low  = patched_q[7:0];
	assign report.patched_high = patched_q[15:8];

endmodule

>>> src/wildcard_byte_pattern_finder.sv
// Top level of the wildcard byte pattern finder: config registers, cell chain and tracker.
//
//  channel   role    payload                                        transfer when
//  stream    sink    data_byte, last_byte                           valid && ready
//  report    source  found, match_offset, matched_*, patched_*      valid && ready
//  cfg       write   cfg_index selects, cfg_data carries the value  cfg_we high
//
// One byte is taken per cycle while the stream is not held off. A byte shifts into the cell
// chain on its transfer edge and its window is checked from the registered cells; the report
// of a buffer is registered once its last byte has passed the stage-one register. Reset clears
// the counter, match flag, report valid and the config registers. The stream is held off only
// while a finished buffer waits behind a report that has not been taken.
module wildcard_byte_pattern_finder #(
	parameter int PATTERN_MAX = wbpf_pkg::PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = wbpf_pkg::OFFSET_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	wbpf_in_if.sink                            stream,
	wbpf_out_if.source                         report,
	input  logic                               cfg_we,
	input  logic [wbpf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wbpf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import wbpf_pkg::*;

	cfg_t                          cfg_q;
	logic [LEN_W-1:0]              len_eff;
	logic                          adv;
	logic                          shift_en;
	cell_stat_t [PATTERN_MAX-1:0]  cells;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:      cfg_q.pattern[7:0]  <= cfg_data;
				REG_PATTERN_HIGH:     cfg_q.pattern[15:8] <= cfg_data;
				REG_PATTERN_LENGTH:   cfg_q.length        <= cfg_data[LEN_W-1:0];
				REG_WILD_MASK:        cfg_q.wild          <= cfg_data[PAT_BYTES-1:0];
				REG_REPLACEMENT_LOW:  cfg_q.repl[7:0]     <= cfg_data;
				REG_REPLACEMENT_HIGH: cfg_q.repl[15:8]    <= cfg_data;
				REG_REPLACEMENT_MASK: cfg_q.repl_mask     <= cfg_data[PAT_BYTES-1:0];
				default: ;
			endcase
		end
	end

	assign len_eff = (cfg_q.length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : cfg_q.length;

	assign stream.ready = adv;
	assign shift_en     = stream.valid && adv;

	// The newest byte enters the top cell; each cell but the lowest hands its byte one place down.
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic [7:0] byte_in;
		if (k == PATTERN_MAX - 1) begin : g_top
			assign byte_in = stream.data_byte;
		end else begin : g_mid
			assign byte_in = cells[k+1].data;
		end
		wbpf_cell #(
			.POS         (k),
			.PATTERN_MAX (PATTERN_MAX)
		) u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.byte_in  (byte_in),
			.pattern  (cfg_q.pattern),
			.wild     (cfg_q.wild),
			.len_eff  (len_eff),
			.stat     (cells[k])
		);
	end

	wbpf_track #(
		.PATTERN_MAX (PATTERN_MAX),
		.OFFSET_BITS (OFFSET_BITS)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_last  (stream.last_byte),
		.adv      (adv),
		.cells    (cells),
		.cfg      (cfg_q),
		.len_eff  (len_eff),
		.report   (report)
	);

endmodule

>>> src/wbpf_checker.sv
// Port-level checks of the wildcard byte pattern finder and their binding.
module wbpf_checker #(
	parameter int OFFSET_BITS = wbpf_pkg::OFFSET_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   found,
	input logic [OFFSET_BITS-1:0] match_offset,
	input logic [63:0]            matched_low,
	input logic [63:0]            matched_high
);

	// A report that is not taken stays up.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("report valid dropped before its transfer");

	// A report that is not taken keeps its offset and its found flag.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(match_offset) && $stable(found))
		else $error("report payload changed while stalled");

	// The stream is only held off behind an untaken report.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("stream stalled without a waiting report");

	// A miss carries a zero offset and an empty window.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_offset == '0 && matched_low == '0 && matched_high == '0)
		else $error("miss report carries match data");

endmodule

bind wildcard_byte_pattern_finder wbpf_checker #(
	.OFFSET_BITS (OFFSET_BITS)
) u_wbpf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (stream.ready),
	.out_valid    (report.valid),
	.out_ready    (report.ready),
	.found        (report.found),
	.match_offset (report.match_offset),
	.matched_low  (report.matched_low),
	.matched_high (report.matched_high)
);

>>> test/wbpf_search_checker.sv
`timescale 1ns / 1ps
// Checker of the wildcard byte pattern finder: predicts each search report and compares it.
module wbpf_search_checker #(
	parameter int OFFSET_BITS = wbpf_pkg::OFFSET_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	wbpf_in_if                              stream,
	wbpf_out_if                             report,
	input  logic                            cfg_we,
	input  logic [wbpf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wbpf_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fault_count,
	output int                              reports_due
);
	import wbpf_pkg::*;

	localparam int CNT_W = OFFSET_BITS + 1;
	localparam int DEPTH = PATTERN_MAX_DEF;

	typedef struct packed {
		logic                   found;
		logic [OFFSET_BITS-1:0] offset;
		logic [15:0][7:0]       matched;
		logic [15:0][7:0]       patched;
	} search_report_t;

	cfg_t                regs;
	logic [15:0][7:0]    window;
	logic [15:0][7:0]    held_window;
	logic [CNT_W-1:0]    seen_count;
	logic                held;
	logic [OFFSET_BITS-1:0] held_offset;
	search_report_t      due_reports [$];

	task clear_search();
		window = '0;
		held_window = '0;
		seen_count = '0;
		held = 1'b0;
		held_offset = '0;
	endtask

	task load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		case (cfg_reg_t'(idx))
			REG_PATTERN_LOW:      regs.pattern[7:0] = value;
			REG_PATTERN_HIGH:     regs.pattern[15:8] = value;
			REG_PATTERN_LENGTH:   regs.length = value[LEN_W-1:0];
			REG_WILD_MASK:        regs.wild = value[15:0];
			REG_REPLACEMENT_LOW:  regs.repl[7:0] = value;
			REG_REPLACEMENT_HIGH: regs.repl[15:8] = value;
			REG_REPLACEMENT_MASK: regs.repl_mask = value[15:0];
			default: ;
		endcase
	endtask

	// Shifts one byte into the window, looks for the first match and, on the
	// last byte of a buffer, queues the report that buffer must produce.
	task scan_byte(input logic [7:0] b, input logic fin);
		int eff;
		int base;
		int k;
		logic hit_now;
		logic [CNT_W-1:0] start;
		search_report_t r;
		eff = (regs.length > DEPTH) ? DEPTH : int'(regs.length);
		for (k = 0; k < DEPTH - 1; k++)
			window[k] = window[k+1];
		window[DEPTH-1] = b;
		if (seen_count != '1) begin
			seen_count = seen_count + 1'b1;
			if (!held && eff > 0 && seen_count >= eff) begin
				start = seen_count - CNT_W'(eff);
				base = DEPTH - eff;
				hit_now = 1'b1;
				for (k = 0; k < eff; k++)
					if (!regs.wild[k] && regs.pattern[k] != window[base+k])
						hit_now = 1'b0;
				// A start beyond the offset range has its top counter bit set.
				if (hit_now && !start[OFFSET_BITS]) begin
					held = 1'b1;
					held_offset = start[OFFSET_BITS-1:0];
					held_window = '0;
					for (k = 0; k < eff; k++)
						held_window[k] = window[base+k];
				end
			end
		end
		if (fin) begin
			r.found = held;
			r.offset = held ? held_offset : '0;
			r.matched = held ? held_window : '0;
			for (k = 0; k < 16; k++)
				r.patched[k] = (held && k < eff && regs.repl_mask[k]) ? held_window[k]
					: regs.repl[k];
			due_reports.push_back(r);
			clear_search();
		end
	endtask

	task log_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function string field_label(input int k);
		case (k)
			0: return "found";
			1: return "match_offset";
			2: return "matched_low";
			3: return "matched_high";
			4: return "patched_low";
			default: return "patched_high";
		endcase
	endfunction

	task check_report(input search_report_t want);
		logic [63:0] want_f [6];
		logic [63:0] got_f [6];
		int k;
		want_f[0] = 64'(want.found);
		want_f[1] = 64'(want.offset);
		want_f[2] = want.matched[7:0];
		want_f[3] = want.matched[15:8];
		want_f[4] = want.patched[7:0];
		want_f[5] = want.patched[15:8];
		got_f[0] = 64'(report.found);
		got_f[1] = 64'(report.match_offset);
		got_f[2] = report.matched_low;
		got_f[3] = report.matched_high;
		got_f[4] = report.patched_low;
		got_f[5] = report.patched_high;
		for (k = 0; k < 6; k++)
			if (got_f[k] !== want_f[k])
				log_fault($sformatf("%s expected %h, got %h", field_label(k), want_f[k],
					got_f[k]));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '0;
			clear_search();
			due_reports.delete();
			reports_due = 0;
		end else begin
			if (cfg_we)
				load_reg(cfg_index, cfg_data);
			if (report.valid && report.ready) begin
				if (due_reports.size() == 0)
					log_fault("report transfer with no report due");
				else
					check_report(due_reports.pop_front());
			end
			if (stream.valid && stream.ready)
				scan_byte(stream.data_byte, stream.last_byte);
			reports_due = due_reports.size();
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench top of the wildcard byte pattern finder: clock, reset, stimulus and verdict.
module tb;
	import wbpf_pkg::*;

	localparam int RANDOM_ITEMS = 1100;
	localparam int CALM_FROM = 950;
	localparam int CYCLE_LIMIT = 200000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fault_count;
	int                    reports_due;
	int                    cycle_count = 0;
	bit                    calm = 1'b0;
	int                    random_items = 0;
	logic [7:0]            frame_bytes [$];
	logic [15:0][7:0]      cur_pattern = '0;
	int                    cur_length = 0;
	logic [15:0]           cur_wild = '0;

	wbpf_in_if stream_if();
	wbpf_out_if #(.OFFSET_BITS(OFFSET_BITS_DEF)) report_if();

	wildcard_byte_pattern_finder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream_if),
		.report   (report_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	wbpf_search_checker #(.OFFSET_BITS(OFFSET_BITS_DEF)) report_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream_if),
		.report     (report_if),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fault_count(fault_count),
		.reports_due(reports_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Report side: random stall bursts, none once the run has calmed down.
	initial begin
		report_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				report_if.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			report_if.ready <= 1'b1;
		end
	end

	// Leaves valid high after the transfer so that the next byte can follow at once.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (!calm && $urandom_range(0, 5) == 0) begin
			stream_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.data_byte <= b;
		stream_if.last_byte <= fin;
		@(posedge clk);
		while (!stream_if.ready) @(posedge clk);
	endtask

	task automatic send_frame();
		int k;
		for (k = 0; k < frame_bytes.size(); k++)
			send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
	endtask

	// Stops the stream and waits until every report is out and the block is quiet.
	task automatic settle();
		stream_if.valid <= 1'b0;
		@(negedge clk);
		while (reports_due != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// The narrow registers sometimes get junk in the unused upper bits.
	task automatic program_regs(input logic [63:0] p_lo, input logic [63:0] p_hi,
		input logic [4:0] len, input logic [15:0] wild, input logic [63:0] r_lo,
		input logic [63:0] r_hi, input logic [15:0] r_mask);
		logic [63:0] junk;
		junk = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : 64'd0;
		write_reg(REG_PATTERN_LOW, p_lo);
		write_reg(REG_PATTERN_HIGH, p_hi);
		write_reg(REG_PATTERN_LENGTH, {junk[63:LEN_W], len});
		write_reg(REG_WILD_MASK, {junk[63:16], wild});
		write_reg(REG_REPLACEMENT_LOW, r_lo);
		write_reg(REG_REPLACEMENT_HIGH, r_hi);
		write_reg(REG_REPLACEMENT_MASK, {junk[63:16], r_mask});
		cur_pattern = {p_hi, p_lo};
		cur_length = (len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : len;
		cur_wild = wild;
	endtask

	task automatic random_setup();
		logic [63:0] p_lo;
		logic [63:0] p_hi;
		logic [63:0] r_lo;
		logic [63:0] r_hi;
		logic [15:0] wild;
		logic [15:0] r_mask;
		logic [4:0]  len;
		int          pick;
		pick = $urandom_range(0, 11);
		if (pick == 0)
			len = 5'd0;
		else if (pick == 1)
			len = 5'd16;
		else if (pick == 2)
			len = 5'($urandom_range(17, 31));
		else if (pick < 5)
			len = 5'($urandom_range(7, 16));
		else
			len = 5'($urandom_range(1, 6));
		pick = $urandom_range(0, 7);
		p_lo = (pick == 0) ? 64'd0 : (pick == 1) ? '1 : {$urandom, $urandom};
		p_hi = (pick == 0) ? 64'd0 : (pick == 1) ? '1 : {$urandom, $urandom};
		pick = $urandom_range(0, 5);
		wild = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom & $urandom);
		pick = $urandom_range(0, 7);
		r_lo = (pick == 0) ? 64'd0 : (pick == 1) ? '1 : {$urandom, $urandom};
		r_hi = (pick == 0) ? 64'd0 : (pick == 1) ? '1 : {$urandom, $urandom};
		r_mask = (pick == 2) ? 16'h0000 : (pick == 3) ? 16'hFFFF : 16'($urandom);
		program_regs(p_lo, p_hi, len, wild, r_lo, r_hi, r_mask);
	endtask

	// Most buffers carry the pattern with random wildcard bytes, some with one bit
	// flipped; the filler leans on pattern bytes so partial matches are common.
	task automatic build_frame();
		int n;
		int pos;
		int k;
		frame_bytes.delete();
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 24);
		for (k = 0; k < n; k++)
			frame_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
				: cur_pattern[$urandom_range(0, 15)]);
		if (cur_length > 0 && $urandom_range(0, 9) < 7) begin
			while (frame_bytes.size() < cur_length)
				frame_bytes.push_back(8'($urandom));
			pos = $urandom_range(0, frame_bytes.size() - cur_length);
			for (k = 0; k < cur_length; k++)
				frame_bytes[pos+k] = cur_wild[k] ? 8'($urandom) : cur_pattern[k];
			if ($urandom_range(0, 4) == 0) begin
				k = $urandom_range(0, cur_length - 1);
				frame_bytes[pos+k] = frame_bytes[pos+k] ^ (8'h01 << $urandom_range(0, 7));
			end
		end
	endtask

	initial begin
		int k;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PATTERN_LOW;
		cfg_data <= '0;
		stream_if.valid <= 1'b0;
		stream_if.data_byte <= 8'h00;
		stream_if.last_byte <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at reset: zero length never matches.
		send_byte(8'h5A, 1'b1);

		// Length 3 with a wildcard in the middle; the first window fails only on its
		// final byte. Mask bits and pattern bytes past the length are set but unused,
		// and the replacement takes a non-wildcard position from the match.
		settle();
		program_regs(64'hDEAD_BEEF_CC33_2211, '1, 5'd3, 16'hFF02,
			64'h0807_0605_0403_0201, 64'h1817_1615_1413_1211, 16'h0023);
		frame_bytes = '{8'h11, 8'h55, 8'h34, 8'h11, 8'h66, 8'h33};
		send_frame();

		// Length above the maximum acts as the maximum; all wildcards, full fill.
		settle();
		program_regs('1, '1, 5'd31, 16'hFFFF, 64'd0, 64'd0, 16'hFFFF);
		frame_bytes.delete();
		for (k = 0; k < 16; k++)
			frame_bytes.push_back(k[0] ? 8'hFF ^ 8'(k) : 8'(k << 4));
		send_frame();

		while (random_items < RANDOM_ITEMS) begin
			settle();
			random_setup();
			repeat ($urandom_range(2, 8)) begin
				build_frame();
				send_frame();
				random_items += frame_bytes.size();
				calm = (random_items >= CALM_FROM);
			end
		end

		settle();
		repeat (12) @(posedge clk);
		if (fault_count == 0 && reports_due == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
